@@ hdl/vvnu_pkg.sv @@
// Package for the Vicsek vectorial-noise particle update block.
// Holds widths, register indexes and the structs that travel along the cell chains.
// No dependencies.
`timescale 1ns / 1ps
package vvnu_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_NEIGHBOURS = 64;

  // Datapath widths
  localparam int CNT_W   = 7;
  localparam int T_W     = 24;   // noise_strength * count
  localparam int NPROD_W = 43;   // noise * t
  localparam int VX_W    = 27;   // noisy sum, signed
  localparam int MAG_W   = 26;   // magnitude of noisy sum
  localparam int SQ_W    = 53;   // sum of squares
  localparam int SCL_W   = 62;   // normalised square for the root
  localparam int HALF_W  = 5;
  localparam int LEN_W   = 31;   // root result
  localparam int NUM_W   = 73;   // division numerator
  localparam int Q_W     = 17;   // quotient bits
  localparam int POS_W   = 26;
  localparam int HEAD_W  = 18;
  localparam int SPD_W   = 19;
  localparam int BOX_W   = 27;
  localparam int NS_W    = 17;
  localparam int SPROD_W = 38;   // speed * heading

  localparam int NORM_STEPS = 5;
  localparam int SQRT_CELLS = 31;
  localparam int DIV_CELLS  = Q_W;
  localparam int PIPE_DEPTH = 6 + NORM_STEPS + SQRT_CELLS + 1 + DIV_CELLS + 3;

  typedef enum logic [1:0] {
    REG_NOISE_STRENGTH = 2'd0,
    REG_SPEED          = 2'd1,
    REG_BOX_WIDTH      = 2'd2,
    REG_BOX_HEIGHT     = 2'd3
  } reg_idx_e;

  // Per-particle data that rides alongside the arithmetic
  typedef struct packed {
    logic              zero;
    logic              neg_x;
    logic              neg_y;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [HALF_W-1:0] half;
  } side_t;

  typedef struct packed {
    logic [SCL_W-1:0] scaled;
    side_t            side;
  } norm_t;

  typedef struct packed {
    logic [SCL_W-1:0] n;
    logic [SCL_W-1:0] r;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] rem_x;
    logic [LEN_W-1:0] rem_y;
    logic [Q_W-1:0]   num_x;
    logic [Q_W-1:0]   num_y;
    logic [Q_W-1:0]   quo_x;
    logic [Q_W-1:0]   quo_y;
    side_t            side;
  } div_t;

endpackage

@@ hdl/vvnu_sqrt_cell.sv @@
// One step of the restoring integer square root, registered.
// Depends on vvnu_pkg.
`timescale 1ns / 1ps
module vvnu_sqrt_cell import vvnu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [HALF_W-1:0] step_i,
  input  sqrt_t             d_i,
  output sqrt_t             q_o
);

  logic [SCL_W-1:0] bit_w;
  logic [SCL_W-1:0] trial;
  sqrt_t            cell_d;
  sqrt_t            cell_q;

  // trial subtract of r + b, b = 4^step
  always_comb begin
    bit_w  = SCL_W'(1) << {step_i, 1'b0};
    trial  = d_i.r + bit_w;
    cell_d = d_i;
    if (d_i.n >= trial) begin
      cell_d.n = d_i.n - trial;
      cell_d.r = (d_i.r >> 1) + bit_w;
    end else begin
      cell_d.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

@@ hdl/vvnu_div_cell.sv @@
// One quotient bit of the restoring division for both heading lanes, registered.
// Depends on vvnu_pkg.
`timescale 1ns / 1ps
module vvnu_div_cell import vvnu_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t d_i,
  output div_t q_o
);

  logic [LEN_W:0] trial_x;
  logic [LEN_W:0] trial_y;
  logic [LEN_W:0] len_ext;
  logic           take_x;
  logic           take_y;
  div_t           cell_d;
  div_t           cell_q;

  // shift in next numerator bit, subtract divisor where it fits
  always_comb begin
    len_ext = {1'b0, d_i.len};
    trial_x = {d_i.rem_x, d_i.num_x[Q_W-1]};
    trial_y = {d_i.rem_y, d_i.num_y[Q_W-1]};
    take_x  = (trial_x >= len_ext);
    take_y  = (trial_y >= len_ext);
    cell_d       = d_i;
    cell_d.num_x = d_i.num_x << 1;
    cell_d.num_y = d_i.num_y << 1;
    cell_d.quo_x = {d_i.quo_x[Q_W-2:0], take_x};
    cell_d.quo_y = {d_i.quo_y[Q_W-2:0], take_y};
    cell_d.rem_x = take_x ? LEN_W'(trial_x - len_ext) : trial_x[LEN_W-1:0];
    cell_d.rem_y = take_y ? LEN_W'(trial_y - len_ext) : trial_y[LEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

@@ hdl/vicsek_vector_noise_update_top.sv @@
// Vicsek particle update with vectorial noise: noisy sum, unit heading, wrapped step.
// Accepts one particle per cycle while no held result is stalled at the output.
// Depth is set by the 31-cell square-root chain and the 17-cell divider chain.
// The whole pipeline advances unless a held result is stalled at the output.
// Async active-low reset clears valid bits and loads register defaults.
`timescale 1ns / 1ps
module vicsek_vector_noise_update_top import vvnu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [BOX_W-1:0]        cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [23:0]      sum_vx_i,
  input  logic signed [23:0]      sum_vy_i,
  input  logic [CNT_W-1:0]        neighbour_count_i,
  input  logic signed [17:0]      noise_x_i,
  input  logic signed [17:0]      noise_y_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [HEAD_W-1:0] heading_x_o,
  output logic signed [HEAD_W-1:0] heading_y_o,
  output logic [POS_W-1:0]        new_x_o,
  output logic [POS_W-1:0]        new_y_o,
  output logic                    zero_heading_o
);

  logic                   adv;
  logic [PIPE_DEPTH-1:0]  vld_q;

  logic [NS_W-1:0]  noise_q;
  logic [SPD_W-1:0] speed_q;
  logic [BOX_W-1:0] boxw_q;
  logic [BOX_W-1:0] boxh_q;

  // stage 1
  logic [CNT_W-1:0]   cnt_sat;
  logic [T_W-1:0]     t_q;
  logic signed [23:0] s1_sx_q, s1_sy_q;
  logic signed [17:0] s1_nx_q, s1_ny_q;
  logic [POS_W-1:0]   s1_px_q, s1_py_q;
  // stage 2
  logic signed [NPROD_W-1:0] np_x_q, np_y_q;
  logic signed [23:0]        s2_sx_q, s2_sy_q;
  logic [POS_W-1:0]          s2_px_q, s2_py_q;
  // stage 3
  logic [NPROD_W-1:0]     nm_x, nm_y, nr_x, nr_y;
  logic signed [VX_W-1:0] add_x, add_y;
  logic signed [VX_W-1:0] vx_q, vy_q;
  logic [POS_W-1:0]       s3_px_q, s3_py_q;
  // stage 4, 5, 6
  side_t             s4_d, s4_q, s5_q;
  logic [2*MAG_W-1:0] sq_x_q, sq_y_q;
  logic [SQ_W-1:0]   ssum;
  norm_t             norm_d;

  norm_t norm_q [NORM_STEPS+1];
  sqrt_t sq     [SQRT_CELLS+1];
  div_t  dv     [DIV_CELLS+1];

  // numerator stage
  logic [NUM_W-1:0] num_x, num_y;
  logic [LEN_W-1:0] len_w;
  div_t             dv_d;
  // heading stage
  logic [Q_W-1:0]           mx, my;
  logic signed [HEAD_W-1:0] hx_d, hy_d, hx_q, hy_q;
  side_t                    hd_q;
  // step product stage
  logic signed [SPROD_W-1:0] sp_x_q, sp_y_q;
  logic signed [HEAD_W-1:0]  hx2_q, hy2_q;
  side_t                     pr_q;
  // output stage
  logic [SPROD_W-1:0]    sm_x, sm_y, sr_x, sr_y;
  logic signed [28:0]    px_sum, py_sum, wx, wy;

  assign adv         = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
      speed_q <= SPD_W'(65536);
      boxw_q  <= BOX_W'(67108864);
      boxh_q  <= BOX_W'(67108864);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_NOISE_STRENGTH: noise_q <= cfg_data_i[NS_W-1:0];
        REG_SPEED:          speed_q <= cfg_data_i[SPD_W-1:0];
        REG_BOX_WIDTH:      boxw_q  <= cfg_data_i;
        REG_BOX_HEIGHT:     boxh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // stage 1: noise scale t
  assign cnt_sat = (neighbour_count_i > CNT_W'(MAX_NEIGHBOURS)) ?
                   CNT_W'(MAX_NEIGHBOURS) : neighbour_count_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q     <= T_W'(noise_q * cnt_sat);
      s1_sx_q <= sum_vx_i;
      s1_sy_q <= sum_vy_i;
      s1_nx_q <= noise_x_i;
      s1_ny_q <= noise_y_i;
      s1_px_q <= pos_x_i;
      s1_py_q <= pos_y_i;
    end
  end

  // stage 2: noise times t
  always_ff @(posedge clk_i) begin
    if (adv) begin
      np_x_q  <= s1_nx_q * $signed({1'b0, t_q});
      np_y_q  <= s1_ny_q * $signed({1'b0, t_q});
      s2_sx_q <= s1_sx_q;
      s2_sy_q <= s1_sy_q;
      s2_px_q <= s1_px_q;
      s2_py_q <= s1_py_q;
    end
  end

  // stage 3: round noise term and add to summed heading
  always_comb begin
    nm_x  = np_x_q[NPROD_W-1] ? NPROD_W'(-np_x_q) : NPROD_W'(np_x_q);
    nm_y  = np_y_q[NPROD_W-1] ? NPROD_W'(-np_y_q) : NPROD_W'(np_y_q);
    nr_x  = nm_x + NPROD_W'(1 << (FRAC_BITS - 1));
    nr_y  = nm_y + NPROD_W'(1 << (FRAC_BITS - 1));
    add_x = np_x_q[NPROD_W-1] ? -$signed({1'b0, nr_x[41:16]}) : $signed({1'b0, nr_x[41:16]});
    add_y = np_y_q[NPROD_W-1] ? -$signed({1'b0, nr_y[41:16]}) : $signed({1'b0, nr_y[41:16]});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_q    <= VX_W'(s2_sx_q) + add_x;
      vy_q    <= VX_W'(s2_sy_q) + add_y;
      s3_px_q <= s2_px_q;
      s3_py_q <= s2_py_q;
    end
  end

  // stage 4: magnitudes and signs
  always_comb begin
    s4_d       = '0;
    s4_d.neg_x = vx_q[VX_W-1];
    s4_d.neg_y = vy_q[VX_W-1];
    s4_d.mag_x = vx_q[VX_W-1] ? MAG_W'(-vx_q) : vx_q[MAG_W-1:0];
    s4_d.mag_y = vy_q[VX_W-1] ? MAG_W'(-vy_q) : vy_q[MAG_W-1:0];
    s4_d.pos_x = s3_px_q;
    s4_d.pos_y = s3_py_q;
  end

  // stage 5: squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q   <= s4_d;
      sq_x_q <= s4_q.mag_x * s4_q.mag_x;
      sq_y_q <= s4_q.mag_y * s4_q.mag_y;
      s5_q   <= s4_q;
    end
  end

  // stage 6: sum of squares, zero detect
  assign ssum = SQ_W'(sq_x_q) + SQ_W'(sq_y_q);

  always_comb begin
    norm_d           = '0;
    norm_d.scaled    = SCL_W'(ssum);
    norm_d.side      = s5_q;
    norm_d.side.zero = (ssum == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      norm_q[0] <= norm_d;
    end
  end

  // normalise by even shifts into [2^60, 2^62), binary search on the shift
  for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
    localparam int SH = 32 >> i;
    norm_t step_d;

    always_comb begin
      step_d = norm_q[i];
      if (norm_q[i].scaled[SCL_W-1 -: SH] == '0) begin
        step_d.scaled    = norm_q[i].scaled << SH;
        step_d.side.half = norm_q[i].side.half + HALF_W'(SH / 2);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        norm_q[i+1] <= step_d;
      end
    end
  end

  // square-root chain
  assign sq[0].n    = norm_q[NORM_STEPS].scaled;
  assign sq[0].r    = '0;
  assign sq[0].side = norm_q[NORM_STEPS].side;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    vvnu_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (HALF_W'(SQRT_CELLS - 1 - k)),
      .d_i    (sq[k]),
      .q_o    (sq[k+1])
    );
  end

  // numerator: mag << (FRAC_BITS + half) plus half the root
  always_comb begin
    len_w      = sq[SQRT_CELLS].r[LEN_W-1:0];
    num_x      = (NUM_W'(sq[SQRT_CELLS].side.mag_x) << (FRAC_BITS + 32'(sq[SQRT_CELLS].side.half)))
                 + NUM_W'(len_w >> 1);
    num_y      = (NUM_W'(sq[SQRT_CELLS].side.mag_y) << (FRAC_BITS + 32'(sq[SQRT_CELLS].side.half)))
                 + NUM_W'(len_w >> 1);
    dv_d       = '0;
    dv_d.len   = len_w;
    dv_d.rem_x = num_x[Q_W +: LEN_W];
    dv_d.rem_y = num_y[Q_W +: LEN_W];
    dv_d.num_x = num_x[Q_W-1:0];
    dv_d.num_y = num_y[Q_W-1:0];
    dv_d.side  = sq[SQRT_CELLS].side;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv[0] <= dv_d;
    end
  end

  // divider chain
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    vvnu_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (dv[k]),
      .q_o   (dv[k+1])
    );
  end

  // heading: clamp to one, apply sign, zero case
  always_comb begin
    mx = (dv[DIV_CELLS].quo_x > Q_W'(1 << FRAC_BITS)) ? Q_W'(1 << FRAC_BITS)
                                                      : dv[DIV_CELLS].quo_x;
    my = (dv[DIV_CELLS].quo_y > Q_W'(1 << FRAC_BITS)) ? Q_W'(1 << FRAC_BITS)
                                                      : dv[DIV_CELLS].quo_y;
    if (dv[DIV_CELLS].side.zero) begin
      hx_d = '0;
      hy_d = '0;
    end else begin
      hx_d = dv[DIV_CELLS].side.neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
      hy_d = dv[DIV_CELLS].side.neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hx_q <= hx_d;
      hy_q <= hy_d;
      hd_q <= dv[DIV_CELLS].side;
    end
  end

  // step product speed * heading
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_x_q <= $signed({1'b0, speed_q}) * hx_q;
      sp_y_q <= $signed({1'b0, speed_q}) * hy_q;
      hx2_q  <= hx_q;
      hy2_q  <= hy_q;
      pr_q   <= hd_q;
    end
  end

  // round step, add to position, wrap once
  always_comb begin
    sm_x   = sp_x_q[SPROD_W-1] ? SPROD_W'(-sp_x_q) : SPROD_W'(sp_x_q);
    sm_y   = sp_y_q[SPROD_W-1] ? SPROD_W'(-sp_y_q) : SPROD_W'(sp_y_q);
    sr_x   = sm_x + SPROD_W'(1 << (FRAC_BITS - 1));
    sr_y   = sm_y + SPROD_W'(1 << (FRAC_BITS - 1));
    px_sum = $signed({3'b0, pr_q.pos_x})
             + (sp_x_q[SPROD_W-1] ? -$signed({8'b0, sr_x[36:16]}) : $signed({8'b0, sr_x[36:16]}));
    py_sum = $signed({3'b0, pr_q.pos_y})
             + (sp_y_q[SPROD_W-1] ? -$signed({8'b0, sr_y[36:16]}) : $signed({8'b0, sr_y[36:16]}));
    if (px_sum >= $signed({2'b0, boxw_q})) begin
      wx = px_sum - $signed({2'b0, boxw_q});
    end else if (px_sum < 0) begin
      wx = px_sum + $signed({2'b0, boxw_q});
    end else begin
      wx = px_sum;
    end
    if (py_sum >= $signed({2'b0, boxh_q})) begin
      wy = py_sum - $signed({2'b0, boxh_q});
    end else if (py_sum < 0) begin
      wy = py_sum + $signed({2'b0, boxh_q});
    end else begin
      wy = py_sum;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      heading_x_o    <= hx2_q;
      heading_y_o    <= hy2_q;
      new_x_o        <= wx[POS_W-1:0];
      new_y_o        <= wy[POS_W-1:0];
      zero_heading_o <= pr_q.zero;
    end
  end

  assign out_valid_o = vld_q[PIPE_DEPTH-1];

endmodule
